>>> sv/hrl_pkg.sv
// Shared types, constants and helpers for the HEX record image loader.
// No dependencies.
`timescale 1ns / 1ps

package hrl_pkg;

   localparam int CAP_W = 25;
   localparam int LEN_W = 25;
   localparam logic [CAP_W-1:0] CAP_RESET = 25'd16777216;

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [7:0] REC_DATA = 8'h00;

   typedef enum logic [2:0] {
      ST_RUN    = 3'd0,
      ST_OK     = 3'd1,
      ST_SUM    = 3'd2,
      ST_FORMAT = 3'd3,
      ST_OVER   = 3'd4
   } status_type;

   typedef enum logic [7:0] {
      PH_LINE  = 8'b0000_0001,
      PH_COUNT = 8'b0000_0010,
      PH_ADDR  = 8'b0000_0100,
      PH_KIND  = 8'b0000_1000,
      PH_DATA  = 8'b0001_0000,
      PH_CHECK = 8'b0010_0000,
      PH_TAIL  = 8'b0100_0000,
      PH_SKIP  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_digit_type;

   // Everything of a result except the offset, whose width is a parameter.
   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic       record_good;
      status_type status;
   } result_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.valid  = 1'b1;
      r.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.nibble = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.nibble = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.nibble = 4'(c - 8'h57);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> sv/hrl_parser.sv
// Record parser: phase machine, digit assembly, checksum and image length.
// Depends on hrl_pkg.
`timescale 1ns / 1ps

module hrl_parser import hrl_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   action,
   input  logic [7:0]             char_code,
   input  logic [CAP_W-1:0]       capacity_limit,
   output logic                   res_valid,
   output result_type             res,
   output logic [OFFSET_BITS-1:0] res_offset
);

   localparam int CmpW = (OFFSET_BITS + 1 > LEN_W) ? OFFSET_BITS + 1 : LEN_W;

   phase_type        phase_ff, phase_in;
   status_type       status_ff, status_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [15:0]      acc_ff, acc_in;
   logic [7:0]       rec_len_ff, rec_len_in;
   logic [7:0]       left_ff, left_in;
   logic [7:0]       sum_ff, sum_in;
   logic [LEN_W-1:0] img_len_ff, img_len_in;

   hex_digit_type    dig;
   logic [15:0]      acc_next;
   logic [1:0]       cnt_next;
   logic             field_done;
   logic [CmpW-1:0]  len_ext;
   logic             over;

   always_comb begin
      dig        = hex_decode(char_code);
      acc_next   = {acc_ff[11:0], dig.nibble};
      cnt_next   = cnt_ff + 2'd1;
      field_done = (phase_ff == PH_ADDR) ? (cnt_ff == 2'd3) : (cnt_ff == 2'd1);
      len_ext    = CmpW'(img_len_ff);
      over       = (len_ext >= CmpW'(capacity_limit))
                   || (len_ext >= (CmpW'(1) << OFFSET_BITS));
   end

   always_comb begin
      phase_in    = phase_ff;
      status_in   = status_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      rec_len_in  = rec_len_ff;
      left_in     = left_ff;
      sum_in      = sum_ff;
      img_len_in  = img_len_ff;
      res_valid   = 1'b0;
      res         = '0;
      res_offset  = '0;

      if (step && status_ff == ST_RUN) begin
         if (action) begin
            status_in = (phase_ff == PH_LINE) ? ST_OK : ST_FORMAT;
            res_valid = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_LINE: begin
                  if (char_code != CHAR_COLON) begin
                     status_in = ST_FORMAT;
                     res_valid = 1'b1;
                  end else begin
                     phase_in = PH_COUNT;
                     cnt_in   = 2'd0;
                     acc_in   = 16'd0;
                     sum_in   = 8'd0;
                  end
               end
               PH_TAIL, PH_SKIP: begin
                  if (char_code == CHAR_NEWLINE) begin
                     phase_in = PH_LINE;
                  end
               end
               default: begin
                  if (!dig.valid) begin
                     status_in = ST_FORMAT;
                     res_valid = 1'b1;
                  end else if (!field_done) begin
                     acc_in = acc_next;
                     cnt_in = cnt_next;
                  end else begin
                     acc_in = 16'd0;
                     cnt_in = 2'd0;
                     case (phase_ff)
                        PH_COUNT: begin
                           rec_len_in = acc_next[7:0];
                           sum_in     = sum_ff + acc_next[7:0];
                           phase_in   = PH_ADDR;
                        end
                        PH_ADDR: begin
                           sum_in   = sum_ff + acc_next[7:0] + acc_next[15:8];
                           phase_in = PH_KIND;
                        end
                        PH_KIND: begin
                           if (acc_next[7:0] != REC_DATA) begin
                              phase_in = PH_SKIP;
                           end else begin
                              left_in  = rec_len_ff;
                              phase_in = (rec_len_ff != 8'd0) ? PH_DATA : PH_CHECK;
                           end
                        end
                        PH_DATA: begin
                           if (over) begin
                              status_in = ST_OVER;
                              res_valid = 1'b1;
                           end else begin
                              sum_in         = sum_ff + acc_next[7:0];
                              img_len_in     = img_len_ff + LEN_W'(1);
                              left_in        = left_ff - 8'd1;
                              if (left_ff == 8'd1) begin
                                 phase_in = PH_CHECK;
                              end
                              res_valid      = 1'b1;
                              res.data_valid = 1'b1;
                              res.data_byte  = acc_next[7:0];
                              res_offset     = len_ext[OFFSET_BITS-1:0];
                           end
                        end
                        PH_CHECK: begin
                           if (8'(8'd0 - sum_ff) != acc_next[7:0]) begin
                              status_in = ST_SUM;
                           end else begin
                              phase_in        = PH_TAIL;
                              res.record_good = 1'b1;
                           end
                           res_valid = 1'b1;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            endcase
         end
      end
      res.status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LINE;
         status_ff  <= ST_RUN;
         cnt_ff     <= 2'd0;
         acc_ff     <= 16'd0;
         rec_len_ff <= 8'd0;
         left_ff    <= 8'd0;
         sum_ff     <= 8'd0;
         img_len_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         status_ff  <= status_in;
         cnt_ff     <= cnt_in;
         acc_ff     <= acc_in;
         rec_len_ff <= rec_len_in;
         left_ff    <= left_in;
         sum_ff     <= sum_in;
         img_len_ff <= img_len_in;
      end
   end

endmodule

>>> sv/hrl_rsp_reg.sv
// Response output register; holds a result while the receiver stalls.
// Depends on hrl_pkg.
`timescale 1ns / 1ps

module hrl_rsp_reg import hrl_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  result_type             res,
   input  logic [OFFSET_BITS-1:0] res_offset,
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output result_type             rsp,
   output logic [OFFSET_BITS-1:0] rsp_offset
);

   logic                   valid_ff, valid_in;
   result_type             res_ff;
   logic [OFFSET_BITS-1:0] off_ff;

   assign ready      = !valid_ff || !rsp_stall;
   assign valid_in   = load ? 1'b1 : (ready ? 1'b0 : valid_ff);
   assign rsp_valid  = valid_ff;
   assign rsp        = res_ff;
   assign rsp_offset = off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
         off_ff <= res_offset;
      end
   end

endmodule

>>> sv/hex_record_image_loader.sv
// HEX record image loader top level: request register, parser, response register.
// Depends on hrl_pkg, hrl_parser and hrl_rsp_reg.
//
// Usage:
//   Request channel (req_valid/req_stall): one request per file character
//   (req_action = 0, req_char_code = ASCII) or an end-of-input marker
//   (req_action = 1). Response channel (rsp_valid/rsp_stall): at most one
//   response per request, carrying a decoded data byte with its packed image
//   offset, a checksum-good flag for a data record, or a final status.
//   Requests that produce nothing yield no response.
//   csr_wr_en/csr_wr_data set the capacity limit; write it only while idle.
// Timing:
//   One request per cycle sustained while the response does not stall. A request
//   is held in the request register and is parsed on the way into the response
//   register, from which its response is presented.
//   The single-pass phase update in the parser sets the rate.
// Reset:
//   Synchronous. Parser waits for ':' at a line start, status running, image
//   length zero, capacity limit 16777216, both channels empty.
// Stall:
//   A stalled response holds; the request register holds behind it and
//   req_stall rises, so no request is lost. Errors and finish are sticky.
`timescale 1ns / 1ps

module hex_record_image_loader import hrl_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [7:0]             req_char_code,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_data_valid,
   output logic [7:0]             rsp_data_byte,
   output logic [OFFSET_BITS-1:0] rsp_byte_offset,
   output logic                   rsp_record_good,
   output logic [2:0]             rsp_status,
   input  logic                   csr_wr_en,
   input  logic [CAP_W-1:0]       csr_wr_data
);

   logic             req_valid_ff, req_valid_in;
   logic             req_action_ff;
   logic [7:0]       req_char_ff;
   logic [CAP_W-1:0] cap_ff;

   logic                   out_ready;
   logic                   step;
   logic                   res_valid;
   result_type             res;
   logic [OFFSET_BITS-1:0] res_offset;
   result_type             rsp;
   logic                   req_take;

   assign step         = req_valid_ff && out_ready;
   assign req_stall    = req_valid_ff && !out_ready;
   assign req_take     = req_valid && !req_stall;
   assign req_valid_in = req_take ? 1'b1 : (step ? 1'b0 : req_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_action_ff <= req_action;
         req_char_ff   <= req_char_code;
      end
   end

   hrl_parser #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .action         (req_action_ff),
      .char_code      (req_char_ff),
      .capacity_limit (cap_ff),
      .res_valid      (res_valid),
      .res            (res),
      .res_offset     (res_offset)
   );

   hrl_rsp_reg #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step && res_valid),
      .res        (res),
      .res_offset (res_offset),
      .ready      (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp),
      .rsp_offset (rsp_byte_offset)
   );

   assign rsp_data_valid  = rsp.data_valid;
   assign rsp_data_byte   = rsp.data_byte;
   assign rsp_record_good = rsp.record_good;
   assign rsp_status      = rsp.status;

endmodule

>>> sv/hrl_checker.sv
// Port-level checks for the HEX record image loader, bound to the top level.
// Depends on hrl_pkg and hex_record_image_loader.
`timescale 1ns / 1ps

module hrl_checker import hrl_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_data_valid,
   input logic [7:0]             rsp_data_byte,
   input logic [OFFSET_BITS-1:0] rsp_byte_offset,
   input logic                   rsp_record_good,
   input logic [2:0]             rsp_status
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_byte_offset) && $stable(rsp_status))
      else $error("stalled response changed");

   a_byte_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_status == ST_RUN && !rsp_record_good)
      else $error("data byte with final status or good flag");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid |-> rsp_data_byte == 8'd0 && rsp_byte_offset == '0)
      else $error("byte fields nonzero without data");

   // final status is the last response
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_status != ST_RUN |=> !rsp_valid)
      else $error("response after final status");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not empty after reset");

endmodule

bind hex_record_image_loader hrl_checker #(.OFFSET_BITS(OFFSET_BITS)) u_hrl_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hex_record_image_loader: streams HEX text requests and
// checks every response against an in-bench parser model or a directed table entry. Needs hrl_pkg and the RTL.

module tb;
   import hrl_pkg::*;

   localparam int OFFSET_BITS   = 24;
   localparam int DIRECTED_ROWS = 28;
   localparam int RANDOM_CHARS  = 450;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic                   data_valid;
      logic [7:0]             data_byte;
      logic [OFFSET_BITS-1:0] byte_offset;
      logic                   record_good;
      status_type             status;
   } image_rsp_type;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_QUIET,
      ROW_RESULT
   } row_mode_type;

   typedef struct packed {
      logic          act;
      logic [7:0]    ch;
      row_mode_type  mode;
      image_rsp_type rsp;
   } stim_row_type;

   localparam image_rsp_type NO_RSP     = '0;
   localparam image_rsp_type GOOD_RSP   = '{1'b0, 8'h00, OFFSET_BITS'(0), 1'b1, ST_RUN};
   localparam image_rsp_type FF_AT_ZERO = '{1'b1, 8'hFF, OFFSET_BITS'(0), 1'b0, ST_RUN};

   // ":0000000000" + junk tail, then ":01ffFF00ff02"
   localparam stim_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{1'b0, CHAR_COLON,   ROW_QUIET,   NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_RESULT,  GOOD_RSP},
      '{1'b0, 8'hFF,        ROW_QUIET,   NO_RSP},
      '{1'b0, 8'h00,        ROW_QUIET,   NO_RSP},
      '{1'b0, CHAR_NEWLINE, ROW_QUIET,   NO_RSP},
      '{1'b0, CHAR_COLON,   ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "1",          ROW_PREDICT, NO_RSP},
      '{1'b0, "f",          ROW_PREDICT, NO_RSP},
      '{1'b0, "f",          ROW_PREDICT, NO_RSP},
      '{1'b0, "F",          ROW_PREDICT, NO_RSP},
      '{1'b0, "F",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "f",          ROW_PREDICT, NO_RSP},
      '{1'b0, "f",          ROW_RESULT,  FF_AT_ZERO},
      '{1'b0, "0",          ROW_PREDICT, NO_RSP},
      '{1'b0, "2",          ROW_RESULT,  GOOD_RSP},
      '{1'b0, CHAR_NEWLINE, ROW_PREDICT, NO_RSP}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_action;
   logic [7:0]             req_char_code;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_data_valid;
   logic [7:0]             rsp_data_byte;
   logic [OFFSET_BITS-1:0] rsp_byte_offset;
   logic                   rsp_record_good;
   logic [2:0]             rsp_status;
   logic                   csr_wr_en;
   logic [CAP_W-1:0]       csr_wr_data;

   // parser model state
   phase_type       ld_phase;
   logic [2:0]      ld_digits;
   logic [15:0]     ld_acc;
   logic [7:0]      ld_len;
   logic [7:0]      ld_kind;
   logic [7:0]      ld_left;
   logic [7:0]      ld_sum;
   longint unsigned ld_image_len;
   status_type      ld_status;
   logic [CAP_W-1:0] cap_limit;

   image_rsp_type expected_q[$];
   image_rsp_type want_rsp;
   int            mismatch_count = 0;
   int            rsp_count = 0;
   int            chars_sent = 0;
   int unsigned   cycle_count = 0;
   bit            calm = 1'b0;
   bit            hold_request = 1'b0;

   hex_record_image_loader #(.OFFSET_BITS(OFFSET_BITS)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_record_good (rsp_record_good),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic bit nibble_of(input logic [7:0] ch, output logic [3:0] nib);
      nib = 4'd0;
      if (ch >= "0" && ch <= "9") begin
         nib = 4'(ch - "0");
      end else if (ch >= "A" && ch <= "F") begin
         nib = 4'(ch - "A" + 10);
      end else if (ch >= "a" && ch <= "f") begin
         nib = 4'(ch - "a" + 10);
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + 8'(nib);
      end
      return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] ch;
      do ch = 8'($urandom); while (ch == CHAR_NEWLINE);
      return ch;
   endfunction

   function automatic logic [7:0] bad_hex_char();
      logic [7:0] ch;
      logic [3:0] nib;
      do ch = 8'($urandom); while (nibble_of(ch, nib));
      return ch;
   endfunction

   function automatic void push_hex(ref logic [7:0] line[$], input logic [15:0] value,
                                    input int digits);
      for (int i = digits - 1; i >= 0; i--) begin
         line.push_back(hex_char(4'(value >> (4 * i))));
      end
   endfunction

   // One text line: header, data and checksum for type 0, junk body otherwise.
   function automatic void build_record(input logic [7:0] kind, input int count,
                                        input bit bad_sum, ref logic [7:0] line[$]);
      logic [15:0] addr;
      logic [7:0]  sum;
      logic [7:0]  data;
      addr = 16'($urandom);
      sum  = 8'(count) + addr[7:0] + addr[15:8] + kind;
      line.delete();
      line.push_back(CHAR_COLON);
      push_hex(line, 16'(count), 2);
      push_hex(line, addr, 4);
      push_hex(line, 16'(kind), 2);
      if (kind == REC_DATA) begin
         repeat (count) begin
            data = 8'($urandom);
            sum  = sum + data;
            push_hex(line, 16'(data), 2);
         end
         sum = 8'h00 - sum;
         if (bad_sum) begin
            sum = sum ^ 8'($urandom_range(255, 1));
         end
         push_hex(line, 16'(sum), 2);
         repeat ($urandom_range(3)) line.push_back(junk_char());
      end else begin
         repeat (2 * count + 2) begin
            line.push_back($urandom_range(1) ? hex_char(4'($urandom)) : junk_char());
         end
      end
      line.push_back(CHAR_NEWLINE);
   endfunction

   // Parser model: advances state by one request, returns the response if any.
   function automatic void loader_step(input logic act, input logic [7:0] ch,
                                       output bit produced, output image_rsp_type r);
      logic [3:0] nib;
      int         need;
      produced = 1'b0;
      r = '0;
      if (ld_status != ST_RUN) begin
         return;
      end
      if (act) begin
         ld_status = (ld_phase == PH_LINE) ? ST_OK : ST_FORMAT;
      end else if (ld_phase == PH_LINE) begin
         if (ch != CHAR_COLON) begin
            ld_status = ST_FORMAT;
         end else begin
            ld_phase  = PH_COUNT;
            ld_digits = 3'd0;
            ld_acc    = 16'd0;
            ld_sum    = 8'd0;
         end
      end else if (ld_phase == PH_TAIL || ld_phase == PH_SKIP) begin
         if (ch == CHAR_NEWLINE) begin
            ld_phase = PH_LINE;
         end
      end else if (!nibble_of(ch, nib)) begin
         ld_status = ST_FORMAT;
      end else begin
         ld_acc    = {ld_acc[11:0], nib};
         ld_digits = ld_digits + 3'd1;
         need      = (ld_phase == PH_ADDR) ? 4 : 2;
         if (ld_digits == need) begin
            ld_digits = 3'd0;
            case (ld_phase)
               PH_COUNT: begin
                  ld_len   = ld_acc[7:0];
                  ld_sum   = ld_sum + ld_len;
                  ld_phase = PH_ADDR;
               end
               PH_ADDR: begin
                  ld_sum   = ld_sum + ld_acc[7:0] + ld_acc[15:8];
                  ld_phase = PH_KIND;
               end
               PH_KIND: begin
                  ld_kind = ld_acc[7:0];
                  if (ld_kind != REC_DATA) begin
                     ld_phase = PH_SKIP;
                  end else begin
                     ld_left  = ld_len;
                     ld_phase = (ld_left != 8'd0) ? PH_DATA : PH_CHECK;
                  end
               end
               PH_DATA: begin
                  if (ld_image_len >= cap_limit || ld_image_len >= (64'd1 << OFFSET_BITS)) begin
                     ld_status = ST_OVER;
                  end else begin
                     produced      = 1'b1;
                     r.data_valid  = 1'b1;
                     r.data_byte   = ld_acc[7:0];
                     r.byte_offset = OFFSET_BITS'(ld_image_len);
                     ld_sum        = ld_sum + ld_acc[7:0];
                     ld_image_len  = ld_image_len + 1;
                     ld_left       = ld_left - 8'd1;
                     if (ld_left == 8'd0) begin
                        ld_phase = PH_CHECK;
                     end
                  end
               end
               PH_CHECK: begin
                  if (ld_acc[7:0] != 8'(8'h00 - ld_sum)) begin
                     ld_status = ST_SUM;
                  end else begin
                     produced      = 1'b1;
                     r.record_good = 1'b1;
                     ld_phase      = PH_TAIL;
                  end
               end
               default: ;
            endcase
            ld_acc = 16'd0;
         end
      end
      if (ld_status != ST_RUN) begin
         produced = 1'b1;
      end
      r.status = ld_status;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d %s got %0h want %0h",
                                   rsp_count, name, got, want));
      end
   endtask

   task automatic send_item(input logic act, input logic [7:0] ch, input row_mode_type mode,
                            input image_rsp_type typed);
      bit            produced;
      image_rsp_type predicted;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_char_code <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
      loader_step(act, ch, produced, predicted);
      if (mode == ROW_RESULT) begin
         expected_q.push_back(typed);
      end else if (mode == ROW_PREDICT && produced) begin
         expected_q.push_back(predicted);
      end
   endtask

   task automatic send_line(input logic [7:0] line[$], input int last);
      for (int i = 0; i <= last; i++) begin
         send_item(1'b0, line[i], ROW_PREDICT, NO_RSP);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      cap_limit = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= !calm && $urandom_range(99) < 15;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing expected", rsp_count));
         end else begin
            want_rsp = expected_q.pop_front();
            check_field("data_valid", rsp_data_valid, want_rsp.data_valid);
            check_field("data_byte", rsp_data_byte, want_rsp.data_byte);
            check_field("byte_offset", rsp_byte_offset, want_rsp.byte_offset);
            check_field("record_good", rsp_record_good, want_rsp.record_good);
            check_field("status", rsp_status, want_rsp.status);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [7:0] line[$];
      logic [7:0] kind;
      logic [7:0] ch;
      int         count;
      int         pick;
      int         term;
      int         pos;
      int         next_cfg;
      bit         hold_done;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = 1'b0;
      req_char_code = 8'h00;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      ld_phase      = PH_LINE;
      ld_digits     = 3'd0;
      ld_acc        = 16'd0;
      ld_len        = 8'd0;
      ld_kind       = 8'd0;
      ld_left       = 8'd0;
      ld_sum        = 8'd0;
      ld_image_len  = 0;
      ld_status     = ST_RUN;
      cap_limit     = CAP_RESET;
      hold_done     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_capacity(CAP_RESET);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(DIRECTED_TABLE[i].act, DIRECTED_TABLE[i].ch, DIRECTED_TABLE[i].mode,
                   DIRECTED_TABLE[i].rsp);
      end

      next_cfg = chars_sent + 150;
      while (chars_sent < DIRECTED_ROWS + RANDOM_CHARS) begin
         if (!hold_done && chars_sent >= 120) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         calm = (chars_sent >= 250 && chars_sent < 340);
         if (chars_sent >= next_cfg) begin
            wait_drained();
            write_capacity(($urandom_range(3) == 0) ? CAP_RESET
                                                    : CAP_W'($urandom_range(CAP_RESET, 4096)));
            next_cfg = chars_sent + 150;
         end
         kind = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 1)) : REC_DATA;
         pick = $urandom_range(99);
         if (pick < 2) begin
            count = 255;
         end else if (pick < 5) begin
            count = $urandom_range(254, 100);
         end else begin
            count = $urandom_range(16);
         end
         build_record(kind, count, 1'b0, line);
         send_line(line, line.size() - 1);
      end
      calm = 1'b0;

      // one terminal event per run; status is sticky from here on
      term = $urandom_range(5);
      wait_drained();
      if (term == 0 || term == 2) begin
         write_capacity(CAP_W'(1));
      end else if (term == 5) begin
         write_capacity($urandom_range(1) ? CAP_W'(1) : CAP_W'(ld_image_len));
      end
      count = $urandom_range(8, 1);
      build_record(REC_DATA, count, term == 1, line);
      case (term)
         0: begin
            send_item(1'b1, 8'($urandom), ROW_PREDICT, NO_RSP);
         end
         1, 5: begin
            send_line(line, line.size() - 1);
         end
         2: begin
            do ch = 8'($urandom); while (ch == CHAR_COLON);
            send_item(1'b0, ch, ROW_PREDICT, NO_RSP);
         end
         3: begin
            pos = $urandom_range(10 + 2 * count, 1);
            line[pos] = bad_hex_char();
            send_line(line, pos);
         end
         default: begin
            pos = $urandom_range(line.size() - 2, 0);
            send_line(line, pos);
            send_item(1'b1, 8'($urandom), ROW_PREDICT, NO_RSP);
         end
      endcase

      // everything after the terminal request is dropped
      repeat (8) begin
         send_item(1'($urandom), 8'($urandom), ROW_PREDICT, NO_RSP);
      end
      wait_drained();

      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
sv/hrl_pkg.sv
sv/hrl_parser.sv
sv/hrl_rsp_reg.sv
sv/hex_record_image_loader.sv
sv/hrl_checker.sv
bench/tb.sv
